[hdl/kwm_pkg.sv]
// ============================================================================
// kwm_pkg
// Shared types, constants and codes of the k-way max-select merge block.
// ============================================================================
package kwm_pkg;

    // list geometry
    localparam int LISTS       = 8;
    localparam int DEPTH       = 1024;
    localparam int LIST_W      = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_W      = $clog2(LISTS * DEPTH);
    localparam int TREE_LEAVES = 1 << LIST_W;
    localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

    // field widths
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 14;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ORDER = 2'd3;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_REJECT,
        OP_POP,
        OP_CLEAR,
        OP_NOP
    } op_t;

    // back-end sequencer states
    typedef enum logic {
        BK_RUN,
        BK_REFILL
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        list_index;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        pop_count;
    } rsp_t;

    typedef struct packed {
        op_t                       op;
        logic [LIST_W-1:0]         list_sel;
        logic signed [VALUE_W-1:0] value;
    } job_t;

endpackage

[hdl/kwm_front.sv]
// ============================================================================
// kwm_front
// Accepts requests, classifies them and holds them in a short queue.
// ============================================================================
module kwm_front
    import kwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic job_valid,
    output job_t job,
    input  logic job_take
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              missing;
    job_t              decoded;

    // classify the incoming request
    always_comb
    begin
        missing          = (32'(req.list_index) >= LISTS);
        decoded.list_sel = LIST_W'(req.list_index);
        decoded.value    = req.value;
        unique case (req.cmd)
            CMD_APPEND: decoded.op = missing ? OP_REJECT : OP_APPEND;
            CMD_POP:    decoded.op = OP_POP;
            CMD_CLEAR:  decoded.op = OP_CLEAR;
            default:    decoded.op = OP_NOP;
        endcase
    end

    // queue handshake
    assign req_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign job_valid = (count_reg != '0);
    assign job       = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (job_take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !job_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && job_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[hdl/kwm_back.sv]
// ============================================================================
// kwm_back
// Executes queued jobs: list store, tail registers, max-select and result.
// ============================================================================
module kwm_back
    import kwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_take,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic signed [VALUE_W-1:0] mem [LISTS * DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    back_state_t               state_reg;
    back_state_t               state_next;
    logic [LEN_W-1:0]          len_reg [LISTS];
    logic signed [VALUE_W-1:0] tail_reg [LISTS];
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [LIST_W-1:0]         refill_sel_reg;
    logic                      rsp_valid_reg;
    rsp_t                      rsp_reg;

    // max-select tree, heap order, leaves at the end
    logic                      node_ok  [TREE_NODES];
    logic signed [VALUE_W-1:0] node_val [TREE_NODES];
    logic [LIST_W-1:0]         node_sel [TREE_NODES];
    logic [LEN_W-1:0]          node_len [TREE_NODES];

    logic                      start;
    logic                      out_free;
    logic [LEN_W-1:0]          sel_len;
    logic signed [VALUE_W-1:0] sel_tail;
    logic                      app_full;
    logic                      app_order;
    logic                      do_write;
    logic                      do_pop;
    logic                      do_clear;
    logic [POS_W-1:0]          refill_pos;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ADDR_W-1:0]         mem_raddr;
    rsp_t                      result;

    // tree over the list tails, ties go to the lower list
    always_comb
    begin
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            if (i < LISTS)
            begin
                node_ok[TREE_LEAVES - 1 + i]  = (len_reg[i] != '0);
                node_val[TREE_LEAVES - 1 + i] = tail_reg[i];
                node_len[TREE_LEAVES - 1 + i] = len_reg[i];
            end
            else
            begin
                node_ok[TREE_LEAVES - 1 + i]  = 1'b0;
                node_val[TREE_LEAVES - 1 + i] = '0;
                node_len[TREE_LEAVES - 1 + i] = '0;
            end
            node_sel[TREE_LEAVES - 1 + i] = LIST_W'(i);
        end
        for (int n = TREE_LEAVES - 2; n >= 0; n--)
        begin
            if (node_ok[2*n+1] && (!node_ok[2*n+2] || node_val[2*n+1] >= node_val[2*n+2]))
            begin
                node_ok[n]  = 1'b1;
                node_val[n] = node_val[2*n+1];
                node_sel[n] = node_sel[2*n+1];
                node_len[n] = node_len[2*n+1];
            end
            else
            begin
                node_ok[n]  = node_ok[2*n+2];
                node_val[n] = node_val[2*n+2];
                node_sel[n] = node_sel[2*n+2];
                node_len[n] = node_len[2*n+2];
            end
        end
    end

    // issue when the result register can take the answer
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign start    = (state_reg == BK_RUN) && job_valid && out_free;
    assign job_take = start;

    // append checks against the selected list
    assign sel_len   = len_reg[job.list_sel];
    assign sel_tail  = tail_reg[job.list_sel];
    assign app_full  = (sel_len >= LEN_W'(DEPTH));
    assign app_order = (sel_len != '0) && (job.value < sel_tail);

    // store addresses
    assign refill_pos = (node_len[0] >= LEN_W'(2)) ? POS_W'(node_len[0] - LEN_W'(2)) : '0;
    assign mem_waddr  = ADDR_W'(job.list_sel) * ADDR_W'(DEPTH) + ADDR_W'(sel_len);
    assign mem_raddr  = ADDR_W'(node_sel[0]) * ADDR_W'(DEPTH) + ADDR_W'(refill_pos);

    // execute the job at the head of the queue
    always_comb
    begin
        do_write            = 1'b0;
        do_pop              = 1'b0;
        do_clear            = 1'b0;
        count_next          = count_reg;
        result.popped_value = '0;
        result.status       = ST_OK;
        case (job.op)
            OP_APPEND:
            begin
                if (app_full)
                begin
                    result.status = ST_FULL;
                end
                else if (app_order)
                begin
                    result.status = ST_ORDER;
                end
                else
                begin
                    do_write = start;
                end
            end
            OP_REJECT:
            begin
                result.status = ST_FULL;
            end
            OP_POP:
            begin
                if (node_ok[0])
                begin
                    do_pop              = start;
                    result.popped_value = node_val[0];
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    result.status = ST_EMPTY;
                end
            end
            OP_CLEAR:
            begin
                do_clear   = start;
                count_next = '0;
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
        result.pop_count = count_next;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (do_pop)
                begin
                    state_next = BK_REFILL;
                end
            end
            BK_REFILL:
            begin
                state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (do_clear)
            begin
                for (int i = 0; i < LISTS; i++)
                begin
                    len_reg[i] <= '0;
                end
            end
            else if (do_write)
            begin
                len_reg[job.list_sel] <= sel_len + 1'b1;
            end
            else if (do_pop)
            begin
                len_reg[node_sel[0]] <= node_len[0] - 1'b1;
            end
        end
    end

    // tail registers and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rsp_reg <= result;
        end
        if (do_pop)
        begin
            refill_sel_reg <= node_sel[0];
        end
        if (do_write)
        begin
            tail_reg[job.list_sel] <= job.value;
        end
        else if (state_reg == BK_REFILL)
        begin
            tail_reg[refill_sel_reg] <= rd_data_reg;
        end
    end

    // list store
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[mem_waddr] <= job.value;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hdl/kway_merge_max_select.sv]
// ============================================================================
// kway_merge_max_select
// Top level of the k-way merge that hands out the largest list tail.
// ============================================================================
// Usage:
//   req channel: req_valid/req_stall with req (cmd, list_index, value).
//     append adds value to the tail of a list, which must grow in ascending
//     order; pop removes the largest tail over all lists; clear empties all.
//   rsp channel: rsp_valid/rsp_stall with rsp (popped_value, status,
//     pop_count), exactly one response per request, in request order.
//   Path: a taken request is registered in the queue; with no request ahead,
//     BK_RUN and the response register free, it issues; its response is registered.
//   Back end: append, clear and unused commands leave it ready; a successful pop is
//     followed by BK_REFILL, which loads the winner's new tail, read from the
//     list store (one registered read port), into its tail register.
//   A two-entry request queue lets requests be taken while the back end
//     works; req_stall rises when that queue is full.
//   Reset empties every list, zeroes the pop count and drops queued requests.
//     The list store is not swept: list lengths gate every read.
//   While rsp_stall holds a pending response, the register keeps its payload
//     and no new job issues; the queue keeps taking requests until it fills.
// ============================================================================
module kway_merge_max_select
    import kwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic job_valid;
    logic job_take;
    job_t job;

    // request queue and classification
    kwm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // list storage and max-select execution
    kwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[hdl/kwm_checker.sv]
// ============================================================================
// kwm_checker
// Port-level checks of the k-way merge block, bound to the top level.
// ============================================================================
module kwm_checker
    import kwm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic [COUNT_W-1:0] last_count_reg;
    logic [2:0]         pending_reg;
    logic               rsp_take;
    logic               req_take;

    assign rsp_take = rsp_valid && !rsp_stall;
    assign req_take = req_valid && !req_stall;

    // pop count of the last delivered response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_count_reg <= rsp.pop_count;
        end
    end

    // requests taken and not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_take && !rsp_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (!req_take && rsp_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // only a successful pop carries a value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0)
        else $error("failed command returned a value");

    // an empty pop leaves the count alone
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.pop_count == last_count_reg)
        else $error("empty pop changed the pop count");

    // every response belongs to an earlier request
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response without an earlier request");

endmodule

bind kway_merge_max_select kwm_checker u_kwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[verif/kway_merge_max_select_test.sv]
// ============================================================================
// kway_merge_max_select_test
// Self-checking bench for the k-way max-select merge. A behavioral model of
// the lists predicts one response per request. Covered: directed corner
// requests, and random ascending loads mixed with pops and errors under
// several stall patterns, including a long response hold-off.
// ============================================================================
module kway_merge_max_select_test
    import kwm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_MAX    = 32'h7fff_ffff;
    localparam int VAL_MIN    = -VAL_MAX - 1;
    localparam int IDLE_HEAVY = 84;
    localparam int IDLE_LIGHT = 17;
    localparam int HOLD_LEN   = 64;
    localparam int RUN_LIMIT  = 1000000;
    localparam int DIR_N      = 24;
    localparam int RAND_N     = 190;

    typedef struct {
        req_t cmd_in;
        bit   fixed;
        rsp_t answer;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // model of the lists
    int               list_words [LISTS][DEPTH];
    int               list_fill  [LISTS];
    logic [COUNT_W-1:0] pops_seen;

    rsp_t        answer_q [$];
    int unsigned mismatches = 0;
    int unsigned cycle_cnt = 0;
    int          send_idle;
    int          recv_stall;
    int          hold_asks;
    stim_row_t   dir_rows [DIR_N];

    kway_merge_max_select i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, answer_q.size());
            $display("[kway_merge_max_select] ERROR");
            $finish;
        end
    end

    function automatic req_t mk_req(logic [CMD_W-1:0] c, int idx, int v);
        req_t r;
        r.cmd        = c;
        r.list_index = idx[INDEX_W-1:0];
        r.value      = v;
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [CMD_W-1:0] c, int idx, int v, bit fixed,
                                         int pv, logic [STAT_W-1:0] st, int cnt);
        stim_row_t row;
        row.cmd_in              = mk_req(c, idx, v);
        row.fixed               = fixed;
        row.answer.popped_value = pv;
        row.answer.status       = st;
        row.answer.pop_count    = cnt[COUNT_W-1:0];
        return row;
    endfunction

    // apply one request to the list model, return the response it gives
    function automatic rsp_t predict_merge(req_t r);
        rsp_t o;
        int   v;
        int   best;
        bit   found;
        o    = '0;
        v    = r.value;
        best = 0;
        found = 1'b0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_APPEND:
            begin
                if (r.list_index >= LISTS || list_fill[r.list_index] >= DEPTH)
                    o.status = ST_FULL;
                else if (list_fill[r.list_index] != 0 &&
                         v < list_words[r.list_index][list_fill[r.list_index] - 1])
                    o.status = ST_ORDER;
                else
                begin
                    list_words[r.list_index][list_fill[r.list_index]] = v;
                    list_fill[r.list_index]++;
                end
            end
            CMD_POP:
            begin
                // strict compare keeps the lowest list on tied tails
                for (int i = 0; i < LISTS; i++)
                begin
                    if (list_fill[i] != 0 && (!found ||
                        list_words[i][list_fill[i] - 1] > list_words[best][list_fill[best] - 1]))
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    o.status = ST_EMPTY;
                else
                begin
                    o.popped_value = list_words[best][list_fill[best] - 1];
                    list_fill[best]--;
                    if (pops_seen != COUNT_MAX)
                        pops_seen++;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < LISTS; i++)
                    list_fill[i] = 0;
                pops_seen = '0;
            end
            default:
            begin
            end
        endcase
        o.pop_count = pops_seen;
        return o;
    endfunction

    // random request, mostly appends that keep each list ascending
    function automatic req_t pick_request();
        req_t   r;
        int     roll;
        int     idx;
        longint t;
        roll = $urandom_range(0, 99);
        idx  = $urandom_range(0, LISTS - 1);
        r    = mk_req(CMD_APPEND, idx, $urandom);
        if (roll < 55)
        begin
            if (list_fill[idx] == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    r.value = $urandom_range(0, 2000) - 1000;
            end
            else
            begin
                t = longint'(list_words[idx][list_fill[idx] - 1]) +
                    $urandom_range(0, $urandom_range(0, 1) ? 50 : (1 << 20));
                if (t > VAL_MAX)
                    t = VAL_MAX;
                r.value = t[31:0];
            end
        end
        else if (roll < 85)
            r.cmd = CMD_POP;
        else if (roll < 90)
        begin
            // value below the tail where there is room for one
            if (list_fill[idx] != 0 && list_words[idx][list_fill[idx] - 1] != VAL_MIN)
            begin
                t = longint'(list_words[idx][list_fill[idx] - 1]) - 1 - $urandom_range(0, 1000);
                if (t < VAL_MIN)
                    t = VAL_MIN;
                r.value = t[31:0];
            end
        end
        else if (roll < 92)
            r.cmd = CMD_CLEAR;
        else if (roll < 95)
            r.cmd = CMD_NONE;
        else
            r.cmd = CMD_W'($urandom_range(0, 3));
        return r;
    endfunction

    // offer one request, predict its response once taken
    task automatic offer(req_t r, bit fixed, rsp_t typed);
        rsp_t guess;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        guess = predict_merge(r);
        answer_q.insert(answer_q.size(), fixed ? typed : guess);
    endtask

    // sender pauses until every response is back
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (answer_q.size() != 0);
    endtask

    task automatic run_random(int n);
        repeat (n)
            offer(pick_request(), 1'b0, '0);
        drain();
    endtask

    task automatic check_answer(rsp_t got);
        rsp_t want;
        if (answer_q.size() == 0)
        begin
            $display("%0t: response with no request outstanding, got %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = answer_q.pop_front();
            if (got.popped_value !== want.popped_value)
            begin
                $display("%0t: popped_value expected %h got %h", $time,
                         want.popped_value, got.popped_value);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.pop_count !== want.pop_count)
            begin
                $display("%0t: pop_count expected %0d got %0d", $time,
                         want.pop_count, got.pop_count);
                mismatches++;
            end
        end
    endtask

    // response side: check, then random stall or a long hold-off
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                check_answer(rsp);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < recv_stall);
        end
    end

    // request side
    initial
    begin
        send_idle  = 0;
        recv_stall = 0;
        hold_asks  = 0;
        pops_seen  = '0;
        for (int i = 0; i < LISTS; i++)
            list_fill[i] = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // corner requests; typed answers where they are evident
        dir_rows = '{
            mk_row(CMD_POP,    0, 0,       1'b1, 0,       ST_EMPTY, 0),
            mk_row(CMD_NONE,   5, -1,      1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 0, VAL_MIN, 1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 0, VAL_MAX, 1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 0, VAL_MAX, 1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 0, 5,       1'b1, 0,       ST_ORDER, 0),
            mk_row(CMD_APPEND, 2, 50,      1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 2, 100,     1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 5, 100,     1'b1, 0,       ST_OK,    0),
            mk_row(CMD_APPEND, 7, -1,      1'b1, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b1, VAL_MAX, ST_OK,    1),
            mk_row(CMD_POP,    0, 0,       1'b1, VAL_MAX, ST_OK,    2),
            // tied tails on lists 2 and 5: list 2, the lower, wins
            mk_row(CMD_POP,    0, 0,       1'b1, 100,     ST_OK,    3),
            mk_row(CMD_APPEND, 2, 70,      1'b1, 0,       ST_OK,    3),
            mk_row(CMD_POP,    3, -7,      1'b0, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b0, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b0, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b0, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b0, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b1, 0,       ST_EMPTY, 8),
            mk_row(CMD_APPEND, 4, VAL_MIN, 1'b0, 0,       ST_OK,    0),
            mk_row(CMD_CLEAR,  7, VAL_MAX, 1'b1, 0,       ST_OK,    0),
            mk_row(CMD_POP,    0, 0,       1'b1, 0,       ST_EMPTY, 0),
            mk_row(CMD_APPEND, 6, 0,       1'b0, 0,       ST_OK,    0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].cmd_in, dir_rows[i].fixed, dir_rows[i].answer);
        drain();

        // random phases under different stall patterns
        run_random(RAND_N);
        send_idle = IDLE_HEAVY;
        run_random(RAND_N);
        send_idle  = 0;
        recv_stall = IDLE_HEAVY;
        run_random(RAND_N);
        send_idle  = IDLE_LIGHT;
        recv_stall = IDLE_LIGHT;
        run_random(RAND_N);

        // long response hold-off while requests keep coming
        send_idle  = 0;
        recv_stall = 0;
        hold_asks++;
        run_random(24);

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[kway_merge_max_select] OK");
        else
            $display("[kway_merge_max_select] ERROR");
        $finish;
    end

endmodule
